/* rtl/krq_pkg.sv */
// Package for the keystroke replay queue: word types, queue entry type,
// cell control struct and constants. No dependencies.
`default_nettype none

package krq_pkg;

  localparam int unsigned KrqDepth = 32;

  localparam logic ModePush = 1'b0;
  localparam logic ModeTick = 1'b1;

  localparam logic EvRelease = 1'b0;
  localparam logic EvPress   = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] key_code;
    logic [7:0] modifier_mask;
  } in_word_t;

  typedef struct packed {
    logic       press;
    logic [7:0] out_key;
    logic [7:0] out_modifier;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [7:0] modifier;
    logic [7:0] key;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/krq_cell.sv */
// One storage cell of the keystroke queue chain: a valid flag and one entry.
// Depends on krq_pkg.
`default_nettype none

module krq_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire krq_pkg::cell_ctrl_t ctrl_i,
  input  wire logic                prev_valid_i,
  input  wire logic                next_valid_i,
  input  wire krq_pkg::entry_t     next_entry_i,
  input  wire krq_pkg::entry_t     push_entry_i,
  output logic                     valid_o,
  output krq_pkg::entry_t          entry_o
);
  import krq_pkg::*;

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;
  logic   load;

  assign load = ctrl_i.push & ~valid_q & prev_valid_i;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.pop) begin
      valid_d = next_valid_i;
      entry_d = next_entry_i;
    end else if (load) begin
      valid_d = 1'b1;
      entry_d = push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

`default_nettype wire

/* rtl/keystroke_replay_queue.sv */
// Top level of the keystroke replay queue: chain of krq_cell storage cells,
// held-key register and a two-word result buffer. Depends on krq_pkg, krq_cell.
//
// Push words enter the first free cell of a chain of QUEUE_DEPTH - 1 cells and
// are dropped when the chain is full; the front cell feeds the tick logic and
// every cell shifts one place towards the front when an entry is pressed. A
// tick is decided in the cycle it is accepted and its
// zero, one or two result words (release, then press) leave through a
// two-word output buffer on the following cycles; the next input word is
// taken once the buffer is empty or its last word is being taken.
`default_nettype none

module keystroke_replay_queue #(
  parameter int unsigned QUEUE_DEPTH = krq_pkg::KrqDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire krq_pkg::in_word_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output krq_pkg::out_word_t      out_data_o
);
  import krq_pkg::*;

  localparam int unsigned NumCells = QUEUE_DEPTH - 1;

  logic       cell_valid [NumCells];
  entry_t     cell_entry [NumCells];
  logic [NumCells-1:0] valid_vec;
  cell_ctrl_t ctrl;
  entry_t     push_entry;

  logic [7:0] held_key_q, held_key_d;
  logic [7:0] held_mod_q, held_mod_d;

  logic [1:0] cnt_q, cnt_d;
  out_word_t  slot_q [2];
  out_word_t  slot_d [2];

  logic in_acc, out_acc, is_tick;
  logic empty, held_any, repeat_key, press_en;
  out_word_t rel_word, prs_word;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;
  assign is_tick = (in_data_i.mode == ModeTick);

  assign push_entry = '{modifier: in_data_i.modifier_mask, key: in_data_i.key_code};
  assign ctrl.push  = in_acc & ~is_tick;
  assign ctrl.pop   = in_acc & is_tick & press_en;

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    logic   prev_v;
    logic   next_v;
    entry_t next_e;
    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = cell_valid[i-1];
    end
    if (i == NumCells - 1) begin : g_tail
      assign next_v = 1'b0;
      assign next_e = cell_entry[i];
    end else begin : g_body
      assign next_v = cell_valid[i+1];
      assign next_e = cell_entry[i+1];
    end
    krq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_valid_i (prev_v),
      .next_valid_i (next_v),
      .next_entry_i (next_e),
      .push_entry_i (push_entry),
      .valid_o      (cell_valid[i]),
      .entry_o      (cell_entry[i])
    );
    assign valid_vec[i] = cell_valid[i];
  end

  assign empty      = ~cell_valid[0];
  assign held_any   = (held_key_q != 8'd0) | (held_mod_q != 8'd0);
  assign repeat_key = ~empty & (held_key_q != 8'd0) & (held_key_q == cell_entry[0].key);
  assign press_en   = ~empty & ~repeat_key;

  assign rel_word = '{press: EvRelease, out_key: held_key_q, out_modifier: held_mod_q,
                      last: ~press_en};
  assign prs_word = '{press: EvPress, out_key: cell_entry[0].key,
                      out_modifier: cell_entry[0].modifier, last: 1'b1};

  always_comb begin
    held_key_d = held_key_q;
    held_mod_d = held_mod_q;
    if (in_acc && is_tick) begin
      if (press_en) begin
        held_key_d = cell_entry[0].key;
        held_mod_d = cell_entry[0].modifier;
      end else begin
        held_key_d = 8'd0;
        held_mod_d = 8'd0;
      end
    end
  end

  always_comb begin
    cnt_d     = cnt_q;
    slot_d[0] = slot_q[0];
    slot_d[1] = slot_q[1];
    if (in_acc && is_tick) begin
      priority if (held_any && press_en) begin
        slot_d[0] = rel_word;
        slot_d[1] = prs_word;
        cnt_d     = 2'd2;
      end else if (held_any) begin
        slot_d[0] = rel_word;
        cnt_d     = 2'd1;
      end else if (press_en) begin
        slot_d[0] = prs_word;
        cnt_d     = 2'd1;
      end else begin
        cnt_d     = 2'd0;
      end
    end else if (out_acc) begin
      slot_d[0] = slot_q[1];
      cnt_d     = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= 2'd0;
      held_key_q <= 8'd0;
      held_mod_q <= 8'd0;
    end else begin
      cnt_q      <= cnt_d;
      held_key_q <= held_key_d;
      held_mod_q <= held_mod_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

  assign in_ready_o  = (cnt_q == 2'd0) | ((cnt_q == 2'd1) & out_ready_i);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot_q[0];

  // The occupied cells always form an unbroken run from the front.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + 1'b1) & valid_vec) == '0)
    else $error("queue cells are not contiguous");

  // A release word always carries a held key or modifier.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.press == EvRelease) |->
      (out_data_o.out_key != 8'd0) || (out_data_o.out_modifier != 8'd0))
    else $error("empty release word");

  // Two buffered words are always a release followed by a final press.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> (slot_q[0].press == EvRelease) && !slot_q[0].last &&
                        (slot_q[1].press == EvPress) && slot_q[1].last)
    else $error("bad result buffer order");

  // The buffer never holds more than two words.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("result buffer overflow");

endmodule

`default_nettype wire
